// ----- rtl/bip_pkg.sv -----
// Package for the BACnet/IP header parser: parse phase codes, error kinds,
// and the structs passed between the front and back parts. No dependencies.
package bip_pkg;

	localparam logic [4:0] PH_TYPE    = 5'd0;
	localparam logic [4:0] PH_FUNC    = 5'd1;
	localparam logic [4:0] PH_LENHI   = 5'd2;
	localparam logic [4:0] PH_LENLO   = 5'd3;
	localparam logic [4:0] PH_VER     = 5'd4;
	localparam logic [4:0] PH_CTRL    = 5'd5;
	localparam logic [4:0] PH_DNH     = 5'd6;
	localparam logic [4:0] PH_DNL     = 5'd7;
	localparam logic [4:0] PH_DLEN    = 5'd8;
	localparam logic [4:0] PH_DADR    = 5'd9;
	localparam logic [4:0] PH_SNH     = 5'd10;
	localparam logic [4:0] PH_SNL     = 5'd11;
	localparam logic [4:0] PH_SLEN    = 5'd12;
	localparam logic [4:0] PH_SADR    = 5'd13;
	localparam logic [4:0] PH_HOP     = 5'd14;
	localparam logic [4:0] PH_AFIRST  = 5'd15;
	localparam logic [4:0] PH_AMAXSEG = 5'd16;
	localparam logic [4:0] PH_AINVOKE = 5'd17;
	localparam logic [4:0] PH_ASEQ    = 5'd18;
	localparam logic [4:0] PH_AWIN    = 5'd19;
	localparam logic [4:0] PH_ASVC    = 5'd20;
	localparam logic [4:0] PH_OK      = 5'd21;
	localparam logic [4:0] PH_ERR     = 5'd22;

	localparam logic [2:0] ERR_NONE  = 3'd0;
	localparam logic [2:0] ERR_BVLC  = 3'd1;
	localparam logic [2:0] ERR_BLEN  = 3'd2;
	localparam logic [2:0] ERR_NVER  = 3'd3;
	localparam logic [2:0] ERR_NTRUNC = 3'd4;
	localparam logic [2:0] ERR_APDU  = 3'd5;

	localparam logic [7:0] BVLC_TYPE_IP = 8'h81;
	localparam logic [7:0] NPDU_VER_CODE = 8'h01;
	localparam int BVLC_HDR = 4;

	// One result item, as it is built from a queued summary and held in the output register.
	typedef struct packed {
		logic [15:0] service_data_length;
		logic [7:0]  svc_code;
		logic [7:0]  txn_id;
		logic [2:0]  apdu_flags;
		logic [3:0]  apdu_kind;
		logic [7:0]  hop_limit;
		logic [15:0] source_network;
		logic [15:0] dest_network;
		logic [7:0]  npdu_control;
		logic [7:0]  bvlc_function;
		logic [2:0]  error_kind;
		logic        frame_ok;
	} result_t;

	// Finished-frame summary from the parsing front to the result back.
	typedef struct packed {
		logic [4:0]  phase;
		logic [2:0]  error_latch;
		logic        short_frame;
		logic        len_bad;
		logic [15:0] bvlc_len;
		logic [15:0] hdr_end;
		logic [7:0]  bvlc_function;
		logic [7:0]  npdu_control;
		logic [15:0] dest_network;
		logic [15:0] source_network;
		logic [7:0]  hop_limit;
		logic [3:0]  apdu_kind;
		logic [2:0]  apdu_flags;
		logic [7:0]  txn_id;
		logic [7:0]  svc_code;
	} summary_t;

endpackage

// ----- rtl/bip_front.sv -----
// Parsing front of the BACnet/IP header parser: walks the header octets and
// emits one frame summary per last octet. Depends on bip_pkg.
module bip_front #(
	parameter int LENGTH_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [7:0]          in_byte,
	input  logic                in_last,
	output logic                sum_valid,
	output bip_pkg::summary_t   sum_data
);

	localparam logic [LENGTH_BITS-1:0] POS_MAX = {LENGTH_BITS{1'b1}};

	logic [LENGTH_BITS-1:0] pos_q;
	logic [4:0]  phase_q;
	logic [15:0] blen_q;
	logic [7:0]  abl_q;
	logic [2:0]  err_q;
	logic [7:0]  func_q, ctrl_q, hop_q, inv_q, svc_q;
	logic [15:0] dnet_q, snet_q, hend_q;
	logic [3:0]  ty_q;
	logic [2:0]  flg_q;

	logic [4:0]  ph_n;
	logic [15:0] blen_n, hend_n;
	logic [7:0]  abl_n, func_n, ctrl_n, hop_n, inv_n, svc_n;
	logic [2:0]  err_n, flg_n;
	logic [15:0] dnet_n, snet_n;
	logic [3:0]  ty_n;
	logic [LENGTH_BITS-1:0] pos_n;
	logic [15:0] idx, idx1;
	logic        take;

	assign idx  = 16'(pos_q);
	assign idx1 = idx + 16'd1;
	assign pos_n = (pos_q < POS_MAX) ? pos_q + 1'b1 : pos_q;
	assign take = !(phase_q >= bip_pkg::PH_VER && {{(17-LENGTH_BITS){1'b0}}, pos_q} >=
		{1'b0, blen_q});

	always_comb begin
		logic [4:0] after_npdu, after_src, after_dest;
		ph_n = phase_q; blen_n = blen_q; abl_n = abl_q; err_n = err_q;
		func_n = func_q; ctrl_n = ctrl_q; hop_n = hop_q; inv_n = inv_q;
		svc_n = svc_q; dnet_n = dnet_q; snet_n = snet_q; hend_n = hend_q;
		ty_n = ty_q; flg_n = flg_q;
		// The successor chains use the stored control octet, except in the
		// control phase itself, where the new octet is the one that counts.
		after_npdu = ctrl_n[7] ? bip_pkg::PH_OK : bip_pkg::PH_AFIRST;
		after_src  = ctrl_n[5] ? bip_pkg::PH_HOP : after_npdu;
		after_dest = ctrl_n[3] ? bip_pkg::PH_SNH : after_src;
		if (take) begin
			case (phase_q)
				bip_pkg::PH_TYPE: begin
					if (in_byte != bip_pkg::BVLC_TYPE_IP) begin
						err_n = bip_pkg::ERR_BVLC; ph_n = bip_pkg::PH_ERR;
					end else ph_n = bip_pkg::PH_FUNC;
				end
				bip_pkg::PH_FUNC: begin func_n = in_byte; ph_n = bip_pkg::PH_LENHI; end
				bip_pkg::PH_LENHI: begin blen_n = {in_byte, 8'd0}; ph_n = bip_pkg::PH_LENLO; end
				bip_pkg::PH_LENLO: begin blen_n[7:0] = in_byte; ph_n = bip_pkg::PH_VER; end
				bip_pkg::PH_VER: begin
					if (in_byte != bip_pkg::NPDU_VER_CODE) begin
						err_n = bip_pkg::ERR_NVER; ph_n = bip_pkg::PH_ERR;
					end else ph_n = bip_pkg::PH_CTRL;
				end
				bip_pkg::PH_CTRL: begin
					ctrl_n = in_byte;
					after_npdu = in_byte[7] ? bip_pkg::PH_OK : bip_pkg::PH_AFIRST;
					after_src  = in_byte[5] ? bip_pkg::PH_HOP : after_npdu;
					after_dest = in_byte[3] ? bip_pkg::PH_SNH : after_src;
					ph_n = in_byte[5] ? bip_pkg::PH_DNH : after_dest;
				end
				bip_pkg::PH_DNH: begin dnet_n[15:8] = in_byte; ph_n = bip_pkg::PH_DNL; end
				bip_pkg::PH_DNL: begin dnet_n[7:0] = in_byte; ph_n = bip_pkg::PH_DLEN; end
				bip_pkg::PH_DLEN: begin
					abl_n = in_byte;
					ph_n = (in_byte == 8'd0) ? after_dest : bip_pkg::PH_DADR;
				end
				bip_pkg::PH_DADR: begin
					abl_n = abl_q - 8'd1;
					if (abl_n == 8'd0) ph_n = after_dest;
				end
				bip_pkg::PH_SNH: begin snet_n[15:8] = in_byte; ph_n = bip_pkg::PH_SNL; end
				bip_pkg::PH_SNL: begin snet_n[7:0] = in_byte; ph_n = bip_pkg::PH_SLEN; end
				bip_pkg::PH_SLEN: begin
					abl_n = in_byte;
					ph_n = (in_byte == 8'd0) ? after_src : bip_pkg::PH_SADR;
				end
				bip_pkg::PH_SADR: begin
					abl_n = abl_q - 8'd1;
					if (abl_n == 8'd0) ph_n = after_src;
				end
				bip_pkg::PH_HOP: begin hop_n = in_byte; ph_n = after_npdu; end
				bip_pkg::PH_AFIRST: begin
					ty_n = in_byte[7:4];
					case (in_byte[7:4])
						4'd0: begin flg_n = in_byte[3:1]; ph_n = bip_pkg::PH_AMAXSEG; end
						4'd1: ph_n = bip_pkg::PH_ASVC;
						4'd2: ph_n = bip_pkg::PH_AINVOKE;
						4'd3: begin
							flg_n = {in_byte[3:2], flg_q[0]}; ph_n = bip_pkg::PH_AINVOKE;
						end
						default: begin err_n = bip_pkg::ERR_APDU; ph_n = bip_pkg::PH_ERR; end
					endcase
				end
				bip_pkg::PH_AMAXSEG: ph_n = bip_pkg::PH_AINVOKE;
				bip_pkg::PH_AINVOKE: begin
					inv_n = in_byte;
					ph_n = flg_q[2] ? bip_pkg::PH_ASEQ : bip_pkg::PH_ASVC;
				end
				bip_pkg::PH_ASEQ: ph_n = bip_pkg::PH_AWIN;
				bip_pkg::PH_AWIN: ph_n = bip_pkg::PH_ASVC;
				bip_pkg::PH_ASVC: begin
					svc_n = in_byte; hend_n = idx1; ph_n = bip_pkg::PH_OK;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; phase_q <= bip_pkg::PH_TYPE; blen_q <= '0; abl_q <= '0;
			err_q <= '0; func_q <= '0; ctrl_q <= '0; hop_q <= '0; inv_q <= '0;
			svc_q <= '0; dnet_q <= '0; snet_q <= '0; hend_q <= '0; ty_q <= '0;
			flg_q <= '0; sum_valid <= 1'b0;
		end else begin
			sum_valid <= in_valid && in_last;
			if (in_valid) begin
				if (in_last) begin
					pos_q <= '0; phase_q <= bip_pkg::PH_TYPE; blen_q <= '0; abl_q <= '0;
					err_q <= '0; func_q <= '0; ctrl_q <= '0; hop_q <= '0; inv_q <= '0;
					svc_q <= '0; dnet_q <= '0; snet_q <= '0; hend_q <= '0; ty_q <= '0;
					flg_q <= '0;
				end else begin
					pos_q <= pos_n; phase_q <= ph_n; blen_q <= blen_n; abl_q <= abl_n;
					err_q <= err_n; func_q <= func_n; ctrl_q <= ctrl_n; hop_q <= hop_n;
					inv_q <= inv_n; svc_q <= svc_n; dnet_q <= dnet_n; snet_q <= snet_n;
					hend_q <= hend_n; ty_q <= ty_n; flg_q <= flg_n;
				end
			end
		end
	end

	// Summary of the frame as it stands after its last octet.
	always_ff @(posedge clk) begin
		if (in_valid && in_last) begin
			sum_data.phase          <= ph_n;
			sum_data.error_latch    <= err_n;
			sum_data.short_frame    <= {{(17-LENGTH_BITS){1'b0}}, pos_n} < 17'(bip_pkg::BVLC_HDR);
			sum_data.len_bad        <= blen_n < 16'(bip_pkg::BVLC_HDR) ||
				{1'b0, blen_n} > {{(17-LENGTH_BITS){1'b0}}, pos_n};
			sum_data.bvlc_len       <= blen_n;
			sum_data.hdr_end        <= hend_n;
			sum_data.bvlc_function  <= func_n;
			sum_data.npdu_control   <= ctrl_n;
			sum_data.dest_network   <= dnet_n;
			sum_data.source_network <= snet_n;
			sum_data.hop_limit      <= hop_n;
			sum_data.apdu_kind      <= ty_n;
			sum_data.apdu_flags     <= flg_n;
			sum_data.txn_id         <= inv_n;
			sum_data.svc_code       <= svc_n;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= bip_pkg::PH_ERR) else $error("phase out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == bip_pkg::PH_ERR) |-> (err_q != bip_pkg::ERR_NONE))
		else $error("error phase without kind");
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_last) |=> (phase_q == bip_pkg::PH_TYPE && pos_q == '0))
		else $error("state not cleared after frame");

endmodule

// ----- rtl/bip_back.sv -----
// Result back of the BACnet/IP header parser: a two-entry queue of frame
// summaries, error priority, and the output register. Depends on bip_pkg.
module bip_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sum_valid,
	input  bip_pkg::summary_t   sum_data,
	output logic                q_ready,
	output logic                res_valid,
	input  logic                res_ready,
	output bip_pkg::result_t    res_data
);

	bip_pkg::summary_t q_mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       pop;
	bip_pkg::summary_t h;
	bip_pkg::result_t  r;

	// Queue keeps space for one summary in flight from the front register;
	// a pop in the same cycle frees the slot that summary will take.
	assign q_ready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && (!sum_valid || pop));
	assign pop = (cnt_q != 2'd0) && (!res_valid || res_ready);
	assign h = q_mem_q[rp_q];

	always_comb begin
		logic [2:0] kind;
		if (h.short_frame || h.error_latch == bip_pkg::ERR_BVLC) kind = bip_pkg::ERR_BVLC;
		else if (h.len_bad) kind = bip_pkg::ERR_BLEN;
		else if (h.error_latch != bip_pkg::ERR_NONE) kind = h.error_latch;
		else if (h.phase <= bip_pkg::PH_CTRL) kind = bip_pkg::ERR_NVER;
		else if (h.phase <= bip_pkg::PH_HOP) kind = bip_pkg::ERR_NTRUNC;
		else if (h.phase <= bip_pkg::PH_ASVC) kind = bip_pkg::ERR_APDU;
		else kind = bip_pkg::ERR_NONE;
		r = '0;
		r.error_kind = kind;
		if (kind == bip_pkg::ERR_NONE) begin
			r.frame_ok = 1'b1;
			r.bvlc_function = h.bvlc_function;
			r.npdu_control = h.npdu_control;
			r.dest_network = h.dest_network;
			r.source_network = h.source_network;
			r.hop_limit = h.hop_limit;
			if (!h.npdu_control[7]) begin
				r.apdu_kind = h.apdu_kind;
				r.apdu_flags = h.apdu_flags;
				r.txn_id = h.txn_id;
				r.svc_code = h.svc_code;
				r.service_data_length = h.bvlc_len - h.hdr_end;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sum_valid) q_mem_q[wp_q] <= sum_data;
		if (pop) res_data <= r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0; res_valid <= 1'b0;
		end else begin
			if (sum_valid) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, sum_valid} - {1'b0, pop};
			if (pop) res_valid <= 1'b1;
			else if (res_ready) res_valid <= 1'b0;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(sum_valid && cnt_q == 2'd2)) else $error("write into full queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_data.frame_ok) |-> (res_data.error_kind == bip_pkg::ERR_NONE))
		else $error("ok result carries an error kind");

endmodule

// ----- rtl/bacnet_ip_header_parser_core.sv -----
// BACnet/IP header parser top level: one frame octet per cycle in while
// s_tready is high, one result item per frame out. Each frame summary is
// registered in the front, queued, then moved to the output register.
// Reset (arst_n, asynchronous) clears the parse state and empties the queue.
// Depends on bip_pkg, bip_front and bip_back.
module bacnet_ip_header_parser_core #(
	parameter int LENGTH_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // frame_byte
	input  logic         s_tlast,   // frame_last
	output logic         m_tvalid,
	input  logic         m_tready,
	// [7:0] bvlc_function, [15:8] npdu_control, [31:16] dest_network,
	// [47:32] source_network, [55:48] hop octet, [59:56] APDU type,
	// [62:60] apdu_flags, [70:63] invoke identifier, [78:71] service octet,
	// [94:79] service_data_length, [95] zero
	output logic [95:0]  m_tdata,
	output logic [3:0]   m_tuser    // [0] frame_ok, [3:1] error_kind
);

	logic              sum_valid;
	bip_pkg::summary_t sum_data;
	bip_pkg::result_t  res;
	logic              acc;

	assign acc = s_tvalid && s_tready;

	bip_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(acc), .in_byte(s_tdata),
		.in_last(s_tlast), .sum_valid(sum_valid), .sum_data(sum_data)
	);

	bip_back u_back (
		.clk(clk), .arst_n(arst_n), .sum_valid(sum_valid), .sum_data(sum_data),
		.q_ready(s_tready), .res_valid(m_tvalid), .res_ready(m_tready), .res_data(res)
	);

	assign m_tdata = {1'b0, res.service_data_length, res.svc_code, res.txn_id,
		res.apdu_flags, res.apdu_kind, res.hop_limit, res.source_network,
		res.dest_network, res.npdu_control, res.bvlc_function};
	assign m_tuser = {res.error_kind, res.frame_ok};

endmodule
